// File: rtl/core/mp3fhd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp3fhd_pkg
// Field codes, lookup tables and constants for the MPEG audio Layer III
// frame header decoder.
// ----------------------------------------------------------------------------
package mp3fhd_pkg;

	// Header field codes
	localparam logic [1:0] VER_MPEG25   = 2'd0;
	localparam logic [1:0] VER_RESERVED = 2'd1;
	localparam logic [1:0] VER_MPEG2    = 2'd2;
	localparam logic [1:0] VER_MPEG1    = 2'd3;
	localparam logic [1:0] LAYER_III    = 2'd1;
	localparam logic [1:0] RIDX_44K1    = 2'd0;
	localparam logic [1:0] RIDX_48K     = 2'd1;
	localparam logic [1:0] RIDX_32K     = 2'd2;
	localparam logic [1:0] RIDX_RES     = 2'd3;
	localparam logic [3:0] BIDX_FREE    = 4'd0;
	localparam logic [3:0] BIDX_BAD     = 4'd15;
	localparam logic [1:0] EMPH_RES     = 2'd2;
	localparam logic [1:0] MODE_MONO    = 2'd3;
	localparam logic [7:0] SYNC_BYTE    = 8'hff;
	localparam logic [2:0] SYNC_TOP     = 3'b111;

	// Frame length limits and per-frame sample counts
	localparam logic [11:0] MIN_FRAME_BYTES = 12'd24;
	localparam logic [11:0] MAX_FRAME_RST   = 12'd1441;
	localparam logic [10:0] SPF_MPEG1       = 11'd1152;
	localparam logic [10:0] SPF_MPEG2       = 11'd576;
	localparam logic [1:0]  CH_MONO         = 2'd1;
	localparam logic [1:0]  CH_STEREO       = 2'd2;

	// Configuration register map
	localparam int          CFG_ADDR_W        = 3;
	localparam logic        CFG_IDX_MAX_FRAME = 1'b0;

	// Scaled bitrate is at most 320, so 9 bits
	localparam int KB_W = 9;

	// For the 44.1 kHz family the length is 160 * k / 49 (k = scaled kbps).
	// Reciprocal of 49 at 22 fractional bits, folded with the factor 160.
	localparam int          RECIP_SHIFT = 22;
	localparam logic [23:0] RECIP_160_49 = 24'd13695840;
	localparam int          PROD_W = KB_W + 24;

	typedef logic [KB_W-1:0] kbps_t;

	// Base sample rate in hertz for MPEG-1
	function automatic logic [15:0] base_rate(input logic [1:0] ri);
		logic [15:0] r;
		case (ri)
			RIDX_44K1: r = 16'd44100;
			RIDX_48K:  r = 16'd48000;
			RIDX_32K:  r = 16'd32000;
			default:   r = 16'd0;
		endcase
		return r;
	endfunction

	// MPEG-1 Layer III bitrate table in kbit/s
	function automatic kbps_t kbps_v1(input logic [3:0] bi);
		kbps_t k;
		case (bi)
			4'd1:    k = 9'd32;
			4'd2:    k = 9'd40;
			4'd3:    k = 9'd48;
			4'd4:    k = 9'd56;
			4'd5:    k = 9'd64;
			4'd6:    k = 9'd80;
			4'd7:    k = 9'd96;
			4'd8:    k = 9'd112;
			4'd9:    k = 9'd128;
			4'd10:   k = 9'd160;
			4'd11:   k = 9'd192;
			4'd12:   k = 9'd224;
			4'd13:   k = 9'd256;
			4'd14:   k = 9'd320;
			default: k = 9'd0;
		endcase
		return k;
	endfunction

	// MPEG-2 / 2.5 Layer III bitrate table in kbit/s
	function automatic kbps_t kbps_v2(input logic [3:0] bi);
		kbps_t k;
		case (bi)
			4'd1:    k = 9'd8;
			4'd2:    k = 9'd16;
			4'd3:    k = 9'd24;
			4'd4:    k = 9'd32;
			4'd5:    k = 9'd40;
			4'd6:    k = 9'd48;
			4'd7:    k = 9'd56;
			4'd8:    k = 9'd64;
			4'd9:    k = 9'd80;
			4'd10:   k = 9'd96;
			4'd11:   k = 9'd112;
			4'd12:   k = 9'd128;
			4'd13:   k = 9'd144;
			4'd14:   k = 9'd160;
			default: k = 9'd0;
		endcase
		return k;
	endfunction

endpackage : mp3fhd_pkg
`default_nettype wire

// File: rtl/core/mp3fhd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp3fhd interfaces
// Valid/ready channels for header words in and decoded results out.
// ----------------------------------------------------------------------------

// Header word channel
interface mp3fhd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] header_word;

	modport source (output valid, output header_word, input ready);
	modport sink   (input valid, input header_word, output ready);
endinterface : mp3fhd_in_if

// Decoded result channel
interface mp3fhd_out_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [15:0] rate_hz;
	logic [11:0] frame_len;
	logic [10:0] samples_per_frame;
	logic [1:0]  channels;

	modport source (output valid, output valid_res, output rate_hz,
		output frame_len, output samples_per_frame, output channels,
		input ready);
	modport sink   (input valid, input valid_res, input rate_hz,
		input frame_len, input samples_per_frame, input channels,
		output ready);
endinterface : mp3fhd_out_if
`default_nettype wire

// File: rtl/core/mp3_frame_header_decode_core.sv
`default_nettype none
// A header passes the stage 1, stage 2 and output (stage 3) registers.
// Throughput: one header per cycle unless stalled; the three stages are
//   field decode and table lookup, the reciprocal multiply, and length
//   select/limit check. An output stall holds full stages; empty ones fill.
// Reset (arst_n low, asynchronous) empties the pipeline and sets
//   the frame length limit to 1441.
// ----------------------------------------------------------------------------
// mp3_frame_header_decode_core
// Checks an MPEG audio Layer III frame header and yields sample rate, frame
// length, samples per frame and channel count.
// ----------------------------------------------------------------------------
module mp3_frame_header_decode_core
	import mp3fhd_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	mp3fhd_in_if.sink            hdr,
	mp3fhd_out_if.source         res,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire [CFG_ADDR_W-1:0] paddr,
	input  wire [31:0]           pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// Configuration register
	logic [11:0] max_frame_q;
	logic        cfg_hit;

	assign cfg_hit = (paddr[2] == CFG_IDX_MAX_FRAME);
	assign pready  = 1'b1;
	assign prdata  = cfg_hit ? {20'd0, max_frame_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= MAX_FRAME_RST;
		end else if (psel && penable && pwrite && pready && cfg_hit) begin
			max_frame_q <= pwdata[11:0];
		end
	end

	// Stage advance: a stage moves when it is empty or the next one moves
	logic vld_s1, vld_s2, vld_s3;
	logic adv1, adv2, adv3;

	assign adv3      = !vld_s3 || res.ready;
	assign adv2      = !vld_s2 || adv3;
	assign adv1      = !vld_s1 || adv2;
	assign hdr.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= hdr.valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: field decode, validity checks, rate and bitrate lookup
	logic [1:0] ver, layer, ri, mode, emph;
	logic [3:0] bi;
	logic       hdr_ok, is_v1;
	kbps_t      kb_raw, kb_eff;
	logic [1:0] rate_shift;

	assign ver   = hdr.header_word[20:19];
	assign layer = hdr.header_word[18:17];
	assign bi    = hdr.header_word[15:12];
	assign ri    = hdr.header_word[11:10];
	assign mode  = hdr.header_word[7:6];
	assign emph  = hdr.header_word[1:0];
	assign is_v1 = (ver == VER_MPEG1);

	assign hdr_ok = (hdr.header_word[31:24] == SYNC_BYTE)
		&& (hdr.header_word[23:21] == SYNC_TOP)
		&& (ver != VER_RESERVED) && (layer == LAYER_III)
		&& (ri != RIDX_RES) && (bi != BIDX_FREE) && (bi != BIDX_BAD)
		&& (emph != EMPH_RES);

	// MPEG-2.5 halves the rate again, which doubles the effective bitrate
	always_comb begin
		kb_raw     = is_v1 ? kbps_v1(bi) : kbps_v2(bi);
		kb_eff     = kb_raw;
		rate_shift = 2'd0;
		case (ver)
			VER_MPEG1: rate_shift = 2'd0;
			VER_MPEG2: rate_shift = 2'd1;
			VER_MPEG25: begin
				rate_shift = 2'd2;
				kb_eff     = {kb_raw[KB_W-2:0], 1'b0};
			end
			default: rate_shift = 2'd0;
		endcase
	end

	logic        ok_s1, v1_s1, mono_s1, pad_s1;
	logic [1:0]  ri_s1;
	logic [15:0] rate_s1;
	kbps_t       kb_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			ok_s1   <= hdr_ok;
			v1_s1   <= is_v1;
			mono_s1 <= (mode == MODE_MONO);
			pad_s1  <= hdr.header_word[9];
			ri_s1   <= ri;
			rate_s1 <= base_rate(ri) >> rate_shift;
			kb_s1   <= kb_eff;
		end
	end

	// Stage 2: reciprocal multiply for 44.1 kHz family, small scalings else
	logic [PROD_W-1:0] prod;
	logic [10:0]       lin;

	assign prod = PROD_W'(kb_s1) * PROD_W'(RECIP_160_49);

	always_comb begin
		case (ri_s1)
			RIDX_48K: lin = 11'(kb_s1) + {1'b0, kb_s1, 1'b0};
			RIDX_32K: lin = 11'(({3'd0, kb_s1, 3'd0} + 12'(kb_s1)) >> 1);
			default:  lin = 11'd0;
		endcase
	end

	logic              ok_s2, v1_s2, mono_s2, pad_s2;
	logic [1:0]        ri_s2;
	logic [15:0]       rate_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [10:0]       lin_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			ok_s2   <= ok_s1;
			v1_s2   <= v1_s1;
			mono_s2 <= mono_s1;
			pad_s2  <= pad_s1;
			ri_s2   <= ri_s1;
			rate_s2 <= rate_s1;
			prod_s2 <= prod;
			lin_s2  <= lin;
		end
	end

	// Stage 3: length select, padding, limit check, output register
	logic [11:0] len;
	logic        len_ok;

	assign len = ((ri_s2 == RIDX_44K1) ? {1'b0, prod_s2[RECIP_SHIFT+:11]} : {1'b0, lin_s2})
		+ 12'(pad_s2);
	assign len_ok = ok_s2 && (len >= MIN_FRAME_BYTES) && (len <= max_frame_q);

	logic        vres_s3;
	logic [15:0] rate_s3;
	logic [11:0] len_s3;
	logic [10:0] spf_s3;
	logic [1:0]  ch_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			vres_s3 <= len_ok;
			rate_s3 <= len_ok ? rate_s2 : 16'd0;
			len_s3  <= len_ok ? len : 12'd0;
			spf_s3  <= !len_ok ? 11'd0 : (v1_s2 ? SPF_MPEG1 : SPF_MPEG2);
			ch_s3   <= !len_ok ? 2'd0 : (mono_s2 ? CH_MONO : CH_STEREO);
		end
	end

	assign res.valid             = vld_s3;
	assign res.valid_res         = vres_s3;
	assign res.rate_hz           = rate_s3;
	assign res.frame_len         = len_s3;
	assign res.samples_per_frame = spf_s3;
	assign res.channels          = ch_s3;

endmodule : mp3_frame_header_decode_core
`default_nettype wire

// File: rtl/core/mp3fhd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp3fhd_checker
// Port-level checks on the result channel of the frame header decoder.
// ----------------------------------------------------------------------------
module mp3fhd_checker
	import mp3fhd_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        o_valid,
	input wire        o_ready,
	input wire        o_valid_res,
	input wire [15:0] o_rate,
	input wire [11:0] o_len,
	input wire [10:0] o_spf,
	input wire [1:0]  o_ch
);

	// Stalled result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid && $stable({o_valid_res, o_rate, o_len, o_spf, o_ch}))
		else $error("result changed while stalled");

	// Rejected header carries all-zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_valid_res |-> (o_rate == 16'd0) && (o_len == 12'd0)
			&& (o_spf == 11'd0) && (o_ch == 2'd0))
		else $error("rejected header with non-zero fields");

	// Accepted header: length at least the minimum, channel count legal
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_valid_res |-> (o_len >= MIN_FRAME_BYTES)
			&& ((o_ch == CH_MONO) || (o_ch == CH_STEREO)))
		else $error("accepted header with bad length or channels");

	// MPEG-1 frames only at the full base rates
	a_v1rate: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_valid_res && (o_spf == SPF_MPEG1) |->
			(o_rate == 16'd44100) || (o_rate == 16'd48000) || (o_rate == 16'd32000))
		else $error("MPEG-1 frame with a non-base sample rate");

endmodule : mp3fhd_checker

bind mp3_frame_header_decode_core mp3fhd_checker u_mp3fhd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.o_valid     (res.valid),
	.o_ready     (res.ready),
	.o_valid_res (res.valid_res),
	.o_rate      (res.rate_hz),
	.o_len       (res.frame_len),
	.o_spf       (res.samples_per_frame),
	.o_ch        (res.channels)
);
`default_nettype wire
